// ===== hw/rtl/pce_pkg.sv =====
`timescale 1ns / 1ps

package pce_pkg;

  // Effect kinds carried with each palette entry.
  localparam logic [2:0] KIND_ORIGINAL = 3'd0;
  localparam logic [2:0] KIND_DARK_60  = 3'd1;
  localparam logic [2:0] KIND_DARK_40  = 3'd2;
  localparam logic [2:0] KIND_DARK_30  = 3'd3;
  localparam logic [2:0] KIND_GREY     = 3'd4;
  localparam logic [2:0] KIND_RED      = 3'd5;
  localparam logic [2:0] KIND_FOG      = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_RED   = 2'd0;
  localparam logic [1:0] REG_KEY_GREEN = 2'd1;
  localparam logic [1:0] REG_KEY_BLUE  = 2'd2;

  // Q16 luma weights; they sum to exactly 65536.
  localparam logic [15:0] LUMA_R = 16'd13938;
  localparam logic [15:0] LUMA_G = 16'd46868;
  localparam logic [15:0] LUMA_B = 16'd4730;

  // Q16 darkening factors, rounded up.
  localparam logic [15:0] DARK_60 = 16'd39322;
  localparam logic [15:0] DARK_40 = 16'd26215;
  localparam logic [15:0] DARK_30 = 16'd19661;

  localparam logic [8:0] RED_BOOST = 9'd32;
  localparam logic [8:0] FOG_BOOST = 9'd16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One request as it enters the pipeline.
  typedef struct packed {
    logic [2:0] kind;
    rgb_t       color;
    logic       last;
  } entry_t;

  // After the first stage: key compare, luma terms and darkened channels.
  typedef struct packed {
    entry_t      entry;
    logic        match;
    logic [23:0] luma_r;
    logic [23:0] luma_g;
    logic [23:0] luma_b;
    rgb_t        dark;
  } prod_t;

  // After the second stage: summed luma.
  typedef struct packed {
    entry_t      entry;
    logic        match;
    logic [23:0] luma;
    rgb_t        dark;
  } luma_t;

  // Finished result.
  typedef struct packed {
    rgb_t color;
    logic match;
    logic last;
  } result_t;

  // Darkening factor for a kind; other kinds do not use it.
  function automatic logic [15:0] dark_factor(logic [2:0] kind);
    logic [15:0] f;
    case (kind)
      KIND_DARK_60: f = DARK_60;
      KIND_DARK_40: f = DARK_40;
      KIND_DARK_30: f = DARK_30;
      default:      f = 16'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/pce_prod_stage.sv =====
`timescale 1ns / 1ps

module pce_prod_stage import pce_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  entry_t in_data,
  input  rgb_t   key,
  output logic   out_valid,
  input  logic   out_ready,
  output prod_t  out_data
);

  prod_t       prod_next;
  logic [15:0] factor;
  logic [23:0] dark_r;
  logic [23:0] dark_g;
  logic [23:0] dark_b;

  // Key compare and all per-channel products in parallel.
  always_comb begin
    factor = dark_factor(in_data.kind);
    dark_r = 24'(in_data.color.red) * 24'(factor);
    dark_g = 24'(in_data.color.green) * 24'(factor);
    dark_b = 24'(in_data.color.blue) * 24'(factor);
    prod_next.entry = in_data;
    prod_next.match = (in_data.color == key);
    prod_next.luma_r = 24'(in_data.color.red) * 24'(LUMA_R);
    prod_next.luma_g = 24'(in_data.color.green) * 24'(LUMA_G);
    prod_next.luma_b = 24'(in_data.color.blue) * 24'(LUMA_B);
    prod_next.dark.red = dark_r[23:16];
    prod_next.dark.green = dark_g[23:16];
    prod_next.dark.blue = dark_b[23:16];
  end

  // The stage takes a new request when it is empty or its request moves on.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= prod_next;
    end
  end

endmodule

// ===== hw/rtl/pce_luma_stage.sv =====
`timescale 1ns / 1ps

module pce_luma_stage import pce_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  prod_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output luma_t out_data
);

  luma_t luma_next;

  // Sum of the three weighted channels; at most 255 * 65536, so 24 bits hold it.
  always_comb begin
    luma_next.entry = in_data.entry;
    luma_next.match = in_data.match;
    luma_next.luma = in_data.luma_r + in_data.luma_g + in_data.luma_b;
    luma_next.dark = in_data.dark;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= luma_next;
    end
  end

endmodule

// ===== hw/rtl/pce_out_stage.sv =====
`timescale 1ns / 1ps

module pce_out_stage import pce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  luma_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t     result_next;
  logic [39:0] fog_prod;
  logic [7:0]  grey;
  logic [7:0]  fog;
  logic [8:0]  red_sum;
  logic [8:0]  fog_sum;
  logic [7:0]  red_tint;
  logic [7:0]  fog_blue;

  // Fog is luma times 0.4 in Q32; the other effects only select and saturate.
  always_comb begin
    fog_prod = 40'(in_data.luma) * 40'(DARK_40);
    fog = fog_prod[39:32];
    grey = in_data.luma[23:16];
    red_sum = {1'b0, grey} + RED_BOOST;
    fog_sum = {1'b0, fog} + FOG_BOOST;
    red_tint = red_sum[8] ? 8'hFF : red_sum[7:0];
    fog_blue = fog_sum[8] ? 8'hFF : fog_sum[7:0];

    result_next.color = in_data.entry.color;
    result_next.match = in_data.match;
    result_next.last = in_data.entry.last;
    if (!in_data.match) begin
      case (in_data.entry.kind)
        KIND_DARK_60, KIND_DARK_40, KIND_DARK_30: begin
          result_next.color = in_data.dark;
        end
        KIND_GREY: begin
          result_next.color = '{red: grey, green: grey, blue: grey};
        end
        KIND_RED: begin
          result_next.color = '{red: red_tint, green: 8'd0, blue: 8'd0};
        end
        KIND_FOG: begin
          result_next.color = '{red: fog, green: fog, blue: fog_blue};
        end
        default: begin
          result_next.color = in_data.entry.color;
        end
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= result_next;
    end
  end

endmodule

// ===== hw/rtl/palette_color_effect.sv =====
`timescale 1ns / 1ps

// Palette color effect: each request carries one RGB palette entry and an effect kind
// (original, three darkening levels, luma grey, red tint, fog) and yields one result.
// An entry equal to the color key passes unchanged with matched_key set. The pipeline
// has three register stages (products and key compare, luma sum, fog product and output
// select), and one request is taken every cycle while results are taken. Each stage holds
// its request under backpressure and fills bubbles, so result_ready reaches item_ready
// through the stages combinationally. Key writes are always accepted (cfg_ready is tied
// high) and are meant to be made while no request is in flight.
module palette_color_effect import pce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [2:0] kind,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic       last_entry,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic       matched_key,
  output logic       last_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  rgb_t    key;
  entry_t  entry;
  logic    s1_valid;
  logic    s1_ready;
  prod_t   s1_data;
  logic    s2_valid;
  logic    s2_ready;
  luma_t   s2_data;
  result_t result;

  // Color key registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_RED:   key.red <= cfg_data;
        REG_KEY_GREEN: key.green <= cfg_data;
        REG_KEY_BLUE:  key.blue <= cfg_data;
        default: ;
      endcase
    end
  end

  assign entry = '{kind: kind, color: '{red: red_in, green: green_in, blue: blue_in},
                   last: last_entry};

  // Three pipeline stages.
  pce_prod_stage u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_data   (entry),
    .key       (key),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  pce_luma_stage u_luma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  pce_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

  assign red_out = result.color.red;
  assign green_out = result.color.green;
  assign blue_out = result.color.blue;
  assign matched_key = result.match;
  assign last_out = result.last;

`ifndef SYNTHESIS
  // A request held in the first stage under backpressure is neither lost nor changed.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_ready |=> s1_valid && $stable(s1_data))
    else $error("first stage request lost or changed while stalled");

  // The same for the second stage.
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ready |=> s2_valid && $stable(s2_data))
    else $error("second stage request lost or changed while stalled");

  // A key match always leaves the entry unchanged through the last stage.
  a_match_pass: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_ready && s2_data.match |=> result_valid && matched_key
      && (result.color == $past(s2_data.entry.color)))
    else $error("matched entry was altered");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pce_pkg::*;

  // The unused kind code behaves like the original color.
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int PIPE_LATENCY = 3;
  localparam int NUM_DIRECTED = 21;
  localparam int NUM_SEGMENTS = 6;
  localparam int SEGMENT_REQUESTS = 235;

  // One directed request, with its result typed in where it is obvious.
  typedef struct packed {
    logic [2:0] kind;
    rgb_t       color;
    logic       last;
    logic       known;
    result_t    want;
  } effect_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [2:0] kind = '0;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic       last_entry = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       matched_key;
  logic       last_out;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // Our copy of the color key, updated when a key write is accepted.
  rgb_t    key_color = '0;
  result_t pending_results[$];
  effect_row_t directed_rows [0:NUM_DIRECTED-1];

  int send_idle_pct = 35;
  int recv_stall_pct = 47;
  int requests_sent = 0;
  int results_checked = 0;
  int key_matches_seen = 0;
  int mismatches = 0;
  int unexpected_results = 0;
  int key_settings = 1;

  palette_color_effect uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .last_entry   (last_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .matched_key  (matched_key),
    .last_out     (last_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Computes the transformed palette entry under the current color key.
  function automatic result_t apply_effect(logic [2:0] k, rgb_t c, logic lst);
    result_t     res;
    logic [63:0] luma;
    logic [63:0] fog;
    logic [31:0] grey;
    logic [15:0] factor;
    res.color = c;
    res.match = (c == key_color);
    res.last  = lst;
    if (!res.match) begin
      luma = 64'(LUMA_R) * c.red + 64'(LUMA_G) * c.green + 64'(LUMA_B) * c.blue;
      grey = 32'(luma >> 16);
      fog  = (luma * 64'(DARK_40)) >> 32;
      case (k)
        KIND_DARK_60, KIND_DARK_40, KIND_DARK_30: begin
          factor = (k == KIND_DARK_60) ? DARK_60 : (k == KIND_DARK_40) ? DARK_40 : DARK_30;
          res.color.red   = 8'((32'(c.red) * factor) >> 16);
          res.color.green = 8'((32'(c.green) * factor) >> 16);
          res.color.blue  = 8'((32'(c.blue) * factor) >> 16);
        end
        KIND_GREY: begin
          res.color.red   = (grey > 255) ? 8'd255 : 8'(grey);
          res.color.green = res.color.red;
          res.color.blue  = res.color.red;
        end
        KIND_RED: begin
          res.color.red   = (grey + RED_BOOST > 255) ? 8'd255 : 8'(grey + RED_BOOST);
          res.color.green = 8'd0;
          res.color.blue  = 8'd0;
        end
        KIND_FOG: begin
          res.color.red   = (fog > 255) ? 8'd255 : 8'(fog);
          res.color.green = res.color.red;
          res.color.blue  = (fog + FOG_BOOST > 255) ? 8'd255 : 8'(fog + FOG_BOOST);
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  // Presents one request, with random gaps ahead of it, and records its result.
  task automatic send_request(input logic [2:0] k, input rgb_t c, input logic lst,
                              input logic known, input result_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    red_in     <= c.red;
    green_in   <= c.green;
    blue_in    <= c.blue;
    last_entry <= lst;
    do @(posedge clk); while (!item_ready);
    pending_results.push_back(known ? want : apply_effect(k, c, lst));
    requests_sent++;
  endtask

  // Stops sending and waits until every pending result has come back.
  task automatic drain_pipeline();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  // Writes one key register; the caller lowers cfg_valid afterwards.
  task automatic write_key(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY_RED:   key_color.red = value;
      REG_KEY_GREEN: key_color.green = value;
      REG_KEY_BLUE:  key_color.blue = value;
      default: begin
      end
    endcase
  endtask

  // Receiver side: random backpressure on results.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest pending one.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        unexpected_results++;
        $display("[%0t] result with no request pending: rgb=%02h%02h%02h match=%0b last=%0b",
                 $realtime, red_out, green_out, blue_out, matched_key, last_out);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (matched_key) key_matches_seen++;
        if (red_out !== want.color.red || green_out !== want.color.green ||
            blue_out !== want.color.blue || matched_key !== want.match ||
            last_out !== want.last) begin
          if (mismatches < 10) begin
            $display("[%0t] mismatch: expected rgb=%02h%02h%02h match=%0b last=%0b",
                     $realtime, want.color.red, want.color.green, want.color.blue,
                     want.match, want.last);
            $display("                 actual   rgb=%02h%02h%02h match=%0b last=%0b",
                     red_out, green_out, blue_out, matched_key, last_out);
          end
          mismatches++;
        end
      end
    end
  end

  // Main sequence: directed table, then random segments under several keys.
  initial begin : stimulus
    rgb_t       c;
    logic [2:0] k;
    int         sel;
    directed_rows = '{
      {KIND_ORIGINAL, 24'h000000, 1'b0, 1'b1, 24'h000000, 1'b1, 1'b0},
      {KIND_GREY,     24'h000000, 1'b0, 1'b1, 24'h000000, 1'b1, 1'b0},
      {KIND_FOG,      24'h000000, 1'b1, 1'b1, 24'h000000, 1'b1, 1'b1},
      {KIND_ORIGINAL, 24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 1'b0, 1'b0},
      {KIND_DARK_60,  24'hFFFFFF, 1'b0, 1'b1, 24'h999999, 1'b0, 1'b0},
      {KIND_DARK_40,  24'hFFFFFF, 1'b0, 1'b1, 24'h666666, 1'b0, 1'b0},
      {KIND_DARK_30,  24'hFFFFFF, 1'b0, 1'b1, 24'h4C4C4C, 1'b0, 1'b0},
      {KIND_GREY,     24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 1'b0, 1'b0},
      {KIND_RED,      24'hFFFFFF, 1'b0, 1'b1, 24'hFF0000, 1'b0, 1'b0},
      {KIND_FOG,      24'hFFFFFF, 1'b1, 1'b1, 24'h666676, 1'b0, 1'b1},
      {KIND_UNUSED,   24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 1'b0, 1'b0},
      {KIND_RED,      24'hFF0000, 1'b0, 1'b0, 26'd0},
      {KIND_RED,      24'h00FF00, 1'b0, 1'b0, 26'd0},
      {KIND_FOG,      24'h0000FF, 1'b0, 1'b0, 26'd0},
      {KIND_DARK_60,  24'hAA5501, 1'b0, 1'b0, 26'd0},
      {KIND_DARK_40,  24'h55AAFE, 1'b0, 1'b0, 26'd0},
      {KIND_DARK_30,  24'h01807F, 1'b0, 1'b0, 26'd0},
      {KIND_GREY,     24'h00FF00, 1'b0, 1'b0, 26'd0},
      {KIND_GREY,     24'h010000, 1'b0, 1'b0, 26'd0},
      {KIND_FOG,      24'h808080, 1'b0, 1'b0, 26'd0},
      {KIND_ORIGINAL, 24'h8001FF, 1'b1, 1'b0, 26'd0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests under the reset key (black).
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_request(directed_rows[i].kind, directed_rows[i].color, directed_rows[i].last,
                   directed_rows[i].known, directed_rows[i].want);
    end

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      // Flow-control pattern changes every two segments.
      case (seg / 2)
        0: begin send_idle_pct = 35; recv_stall_pct = 47; end
        1: begin send_idle_pct = 47; recv_stall_pct = 35; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase

      // New key only once the pipeline is empty.
      drain_pipeline();
      case (seg)
        0: c = 24'hFFFFFF;
        1: c = 24'h00FF00;
        3: c = 24'hFF00FF;
        5: c = 24'h000000;
        default: c = rgb_t'($urandom_range(24'hFFFFFF));
      endcase
      write_key(REG_KEY_RED, c.red);
      write_key(REG_KEY_GREEN, c.green);
      write_key(REG_KEY_BLUE, c.blue);
      @(negedge clk);
      cfg_valid <= 1'b0;
      key_settings++;

      for (int n = 0; n < SEGMENT_REQUESTS; n++) begin
        k   = 3'($urandom_range(7));
        sel = $urandom_range(15);
        // Mix exact key hits, near misses, extremes and plain random colors.
        if (sel < 2) begin
          c = key_color;
        end else if (sel == 2) begin
          c = key_color ^ (24'd1 << $urandom_range(23));
        end else if (sel == 3) begin
          c.red   = $urandom_range(1) ? 8'hFF : 8'h00;
          c.green = $urandom_range(1) ? 8'hFF : 8'h00;
          c.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        end else begin
          c = rgb_t'($urandom_range(24'hFFFFFF));
        end
        send_request(k, c, 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    drain_pipeline();
    $display("Sent %0d palette entries and checked %0d results (%0d key matches).",
             requests_sent, results_checked, key_matches_seen);
    $display("Covered %0d color keys, all effect kinds and three flow-control patterns.",
             key_settings);
    if (mismatches == 0 && unexpected_results == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
